FILE: rtl/core/ipv6p_pkg.sv
// ipv6p_pkg: types, character codes and constants shared by the ipv6 text parser
// used by ipv6p_front, ipv6p_back and ipv6_text_address_parser_unit
// no dependencies
`default_nettype none

package ipv6p_pkg;

  localparam int unsigned NUM_GROUPS  = 8;
  localparam int unsigned MAX_DIGITS  = 4;
  localparam int unsigned MAX_PDIGITS = 3;
  localparam int unsigned PREFIX_MAX  = 128;
  localparam int unsigned DEC_BASE    = 10;
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  typedef enum logic [7:0] {
    PH_START       = 8'b0000_0001,
    PH_START_COLON = 8'b0000_0010,
    PH_HEAD_GROUP  = 8'b0000_0100,
    PH_HEAD_COLON  = 8'b0000_1000,
    PH_ABBREV      = 8'b0001_0000,
    PH_TAIL_GROUP  = 8'b0010_0000,
    PH_TAIL_COLON  = 8'b0100_0000,
    PH_PREFIX      = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [7:0]  prefix_len;
    logic [63:0] mask_high;
    logic [63:0] mask_low;
  } out_t;

  // classified character
  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
    logic       is_dec;
    logic       is_colon;
    logic       is_slash;
    logic       pm;
    logic       last;
  } cls_t;

endpackage

`default_nettype wire

FILE: rtl/core/ipv6p_front.sv
// ipv6p_front: holds the mode register, classifies each character item
// and buffers classified items in a short queue toward the parser
// depends on ipv6p_pkg
`default_nettype none

module ipv6p_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                full_o,
  input  wire ipv6p_pkg::in_t in_i,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic           cfg_data_i,
  output logic                mid_valid_o,
  input  wire logic           mid_pop_i,
  output ipv6p_pkg::cls_t     mid_o
);

  logic                           pm_q;
  ipv6p_pkg::cls_t                cls;
  ipv6p_pkg::cls_t                mem_q [ipv6p_pkg::Q_DEPTH];
  logic [ipv6p_pkg::Q_PTR_W-1:0]  wptr_q, rptr_q;
  logic [ipv6p_pkg::Q_CNT_W-1:0]  cnt_q;
  logic                           wr, rd;
  logic [7:0]                     c;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q <= 1'b0;
    end else if (cfg_valid_i) begin
      pm_q <= cfg_data_i;
    end
  end

  always_comb begin
    c            = in_i.character;
    cls.is_hex   = 1'b0;
    cls.value    = 4'd0;
    cls.is_dec   = 1'b0;
    if (c >= ipv6p_pkg::CHAR_0 && c <= ipv6p_pkg::CHAR_9) begin
      cls.is_hex = 1'b1;
      cls.is_dec = 1'b1;
      cls.value  = 4'(c - ipv6p_pkg::CHAR_0);
    end else if (c >= ipv6p_pkg::CHAR_LA && c <= ipv6p_pkg::CHAR_LF) begin
      cls.is_hex = 1'b1;
      cls.value  = 4'(c - ipv6p_pkg::CHAR_LA + 8'd10);
    end else if (c >= ipv6p_pkg::CHAR_UA && c <= ipv6p_pkg::CHAR_UF) begin
      cls.is_hex = 1'b1;
      cls.value  = 4'(c - ipv6p_pkg::CHAR_UA + 8'd10);
    end
    cls.is_colon = (c == ipv6p_pkg::CHAR_COLON);
    cls.is_slash = pm_q && (c == ipv6p_pkg::CHAR_SLASH);
    cls.pm       = pm_q;
    cls.last     = in_i.last;
  end

  assign full_o      = (cnt_q == ipv6p_pkg::Q_CNT_W'(ipv6p_pkg::Q_DEPTH));
  assign mid_valid_o = (cnt_q != '0);
  assign wr          = push_i && !full_o;
  assign rd          = mid_pop_i && mid_valid_o;
  assign mid_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + 1'b1;
      if (rd) rptr_q <= rptr_q + 1'b1;
      if (wr && !rd) cnt_q <= cnt_q + 1'b1;
      else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ipv6p_back.sv
// ipv6p_back: parser state machine over classified items, builds the
// address and mask on the last item and queues results
// depends on ipv6p_pkg
`default_nettype none

module ipv6p_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            mid_valid_i,
  output logic                 mid_pop_o,
  input  wire ipv6p_pkg::cls_t mid_i,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output ipv6p_pkg::out_t      out_o
);

  logic [15:0]       head_q [ipv6p_pkg::NUM_GROUPS];
  logic [15:0]       head_d [ipv6p_pkg::NUM_GROUPS];
  logic [15:0]       tail_q [ipv6p_pkg::NUM_GROUPS];
  logic [15:0]       tail_d [ipv6p_pkg::NUM_GROUPS];
  logic [15:0]       head_f [ipv6p_pkg::NUM_GROUPS];
  logic [15:0]       tail_f [ipv6p_pkg::NUM_GROUPS];
  logic [15:0]       grp    [ipv6p_pkg::NUM_GROUPS];
  logic [15:0]       acc_q, acc_d;
  logic [2:0]        dig_q, dig_d;
  logic [3:0]        hc_q, hc_d, hc_f;
  logic [3:0]        tc_q, tc_d, tc_f;
  ipv6p_pkg::phase_e ph_q, ph_d;
  logic [9:0]        pacc_q, pacc_d;
  logic [1:0]        pdig_q, pdig_d;
  logic              fail_q, fail_d;
  logic              take, room, ok;
  logic [4:0]        used;
  logic [3:0]        pos;
  logic [7:0]        plen;
  logic [127:0]      mask;
  ipv6p_pkg::out_t   res;

  ipv6p_pkg::out_t                mem_q [ipv6p_pkg::Q_DEPTH];
  logic [ipv6p_pkg::Q_PTR_W-1:0]  wptr_q, rptr_q;
  logic [ipv6p_pkg::Q_CNT_W-1:0]  cnt_q;
  logic                           wr, rd;

  assign room      = (cnt_q != ipv6p_pkg::Q_CNT_W'(ipv6p_pkg::Q_DEPTH));
  assign mid_pop_o = room;
  assign take      = mid_valid_i && room;
  assign used      = 5'(hc_q) + 5'd1 + 5'(tc_q);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    acc_d  = acc_q;
    dig_d  = dig_q;
    hc_d   = hc_q;
    tc_d   = tc_q;
    ph_d   = ph_q;
    pacc_d = pacc_q;
    pdig_d = pdig_q;
    fail_d = fail_q;

    if (take && !fail_q) begin
      case (ph_q)
        ipv6p_pkg::PH_START: begin
          if (mid_i.is_colon) begin
            ph_d = ipv6p_pkg::PH_START_COLON;
          end else if (mid_i.is_hex) begin
            acc_d = 16'(mid_i.value);
            dig_d = 3'd1;
            ph_d  = ipv6p_pkg::PH_HEAD_GROUP;
          end else begin
            fail_d = 1'b1;
          end
        end
        ipv6p_pkg::PH_START_COLON: begin
          if (mid_i.is_colon) ph_d = ipv6p_pkg::PH_ABBREV;
          else fail_d = 1'b1;
        end
        ipv6p_pkg::PH_HEAD_GROUP: begin
          if (mid_i.is_hex && dig_q < 3'(ipv6p_pkg::MAX_DIGITS)) begin
            acc_d = {acc_q[11:0], mid_i.value};
            dig_d = dig_q + 3'd1;
          end else begin
            if (hc_q < 4'(ipv6p_pkg::NUM_GROUPS)) begin
              head_d[hc_q[2:0]] = acc_q;
              hc_d = hc_q + 4'd1;
            end
            if (hc_d >= 4'(ipv6p_pkg::NUM_GROUPS)) begin
              if (mid_i.is_slash) ph_d = ipv6p_pkg::PH_PREFIX;
              else fail_d = 1'b1;
            end else if (mid_i.is_colon) begin
              ph_d = ipv6p_pkg::PH_HEAD_COLON;
            end else begin
              fail_d = 1'b1;
            end
          end
        end
        ipv6p_pkg::PH_HEAD_COLON: begin
          if (mid_i.is_colon) begin
            ph_d = ipv6p_pkg::PH_ABBREV;
          end else if (mid_i.is_hex) begin
            acc_d = 16'(mid_i.value);
            dig_d = 3'd1;
            ph_d  = ipv6p_pkg::PH_HEAD_GROUP;
          end else begin
            fail_d = 1'b1;
          end
        end
        ipv6p_pkg::PH_ABBREV: begin
          if (mid_i.is_hex) begin
            if (used < 5'(ipv6p_pkg::NUM_GROUPS)) begin
              acc_d = 16'(mid_i.value);
              dig_d = 3'd1;
              ph_d  = ipv6p_pkg::PH_TAIL_GROUP;
            end else begin
              fail_d = 1'b1;
            end
          end else if (mid_i.is_slash) begin
            ph_d = ipv6p_pkg::PH_PREFIX;
          end else begin
            fail_d = 1'b1;
          end
        end
        ipv6p_pkg::PH_TAIL_GROUP: begin
          if (mid_i.is_hex && dig_q < 3'(ipv6p_pkg::MAX_DIGITS)) begin
            acc_d = {acc_q[11:0], mid_i.value};
            dig_d = dig_q + 3'd1;
          end else begin
            if (tc_q < 4'(ipv6p_pkg::NUM_GROUPS)) begin
              tail_d[tc_q[2:0]] = acc_q;
              tc_d = tc_q + 4'd1;
            end
            if (mid_i.is_slash) begin
              ph_d = ipv6p_pkg::PH_PREFIX;
            end else if (mid_i.is_colon &&
                         (5'(hc_q) + 5'd1 + 5'(tc_d)) < 5'(ipv6p_pkg::NUM_GROUPS)) begin
              ph_d = ipv6p_pkg::PH_TAIL_COLON;
            end else begin
              fail_d = 1'b1;
            end
          end
        end
        ipv6p_pkg::PH_TAIL_COLON: begin
          if (mid_i.is_hex) begin
            acc_d = 16'(mid_i.value);
            dig_d = 3'd1;
            ph_d  = ipv6p_pkg::PH_TAIL_GROUP;
          end else begin
            fail_d = 1'b1;
          end
        end
        ipv6p_pkg::PH_PREFIX: begin
          if (mid_i.is_dec && pdig_q < 2'(ipv6p_pkg::MAX_PDIGITS)) begin
            pacc_d = 10'(pacc_q * 10'(ipv6p_pkg::DEC_BASE) + 10'(mid_i.value));
            pdig_d = pdig_q + 2'd1;
          end else begin
            fail_d = 1'b1;
          end
        end
        default: begin
          fail_d = 1'b1;
        end
      endcase
    end

    // end of text: final commit and result
    head_f = head_d;
    tail_f = tail_d;
    hc_f   = hc_d;
    tc_f   = tc_d;
    ok     = 1'b0;
    if (!fail_d) begin
      case (ph_d)
        ipv6p_pkg::PH_HEAD_GROUP: begin
          if (hc_d < 4'(ipv6p_pkg::NUM_GROUPS)) begin
            head_f[hc_d[2:0]] = acc_d;
            hc_f = hc_d + 4'd1;
          end
          ok = (hc_f == 4'(ipv6p_pkg::NUM_GROUPS)) && !mid_i.pm;
        end
        ipv6p_pkg::PH_TAIL_GROUP: begin
          if (tc_d < 4'(ipv6p_pkg::NUM_GROUPS)) begin
            tail_f[tc_d[2:0]] = acc_d;
            tc_f = tc_d + 4'd1;
          end
          ok = !mid_i.pm;
        end
        ipv6p_pkg::PH_ABBREV: begin
          ok = !mid_i.pm;
        end
        ipv6p_pkg::PH_PREFIX: begin
          ok = mid_i.pm && (pdig_d != 2'd0) && (pacc_d <= 10'(ipv6p_pkg::PREFIX_MAX));
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end

    for (int p = 0; p < ipv6p_pkg::NUM_GROUPS; p++) begin
      pos    = 4'(p) + tc_f;
      grp[p] = 16'd0;
      if (4'(p) < hc_f) grp[p] = head_f[p];
      if (pos[3]) grp[p] = tail_f[pos[2:0]];
    end

    plen = (ok && mid_i.pm) ? pacc_d[7:0] : 8'd0;
    mask = ~({128{1'b1}} >> plen);

    res.ok           = ok;
    res.address_high = ok ? {grp[0], grp[1], grp[2], grp[3]} : 64'd0;
    res.address_low  = ok ? {grp[4], grp[5], grp[6], grp[7]} : 64'd0;
    res.prefix_len   = plen;
    res.mask_high    = mask[127:64];
    res.mask_low     = mask[63:0];

    if (take && mid_i.last) begin
      acc_d  = 16'd0;
      dig_d  = 3'd0;
      hc_d   = 4'd0;
      tc_d   = 4'd0;
      ph_d   = ipv6p_pkg::PH_START;
      pacc_d = 10'd0;
      pdig_d = 2'd0;
      fail_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 16'd0;
      dig_q  <= 3'd0;
      hc_q   <= 4'd0;
      tc_q   <= 4'd0;
      ph_q   <= ipv6p_pkg::PH_START;
      pacc_q <= 10'd0;
      pdig_q <= 2'd0;
      fail_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      dig_q  <= dig_d;
      hc_q   <= hc_d;
      tc_q   <= tc_d;
      ph_q   <= ph_d;
      pacc_q <= pacc_d;
      pdig_q <= pdig_d;
      fail_q <= fail_d;
    end
  end

  // result queue
  assign wr      = take && mid_i.last;
  assign rd      = pop_i && !empty_o;
  assign empty_o = (cnt_q == '0);
  assign out_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + 1'b1;
      if (rd) rptr_q <= rptr_q + 1'b1;
      if (wr && !rd) cnt_q <= cnt_q + 1'b1;
      else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ipv6_text_address_parser_unit.sv
// ipv6_text_address_parser_unit: top level of the ipv6 text address parser
// one character item per cycle while the front queue has room; the front queue
// registers each item, then the parser takes it and queues the result on the
// last character; a full result queue stalls the parser and then the input
// reset is asynchronous: queues empty, mode cleared to plain, parser at start
// depends on ipv6p_pkg, ipv6p_front, ipv6p_back
`default_nettype none

module ipv6_text_address_parser_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire ipv6p_pkg::in_t in_i,
  output logic                empty,
  input  wire logic           pop,
  output ipv6p_pkg::out_t     out_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic           cfg_data_i
);

  logic            mid_valid;
  logic            mid_pop;
  ipv6p_pkg::cls_t mid;

  ipv6p_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .mid_valid_o (mid_valid),
    .mid_pop_i   (mid_pop),
    .mid_o       (mid)
  );

  ipv6p_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_pop_o   (mid_pop),
    .mid_i       (mid),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking testbench for ipv6_text_address_parser_unit
// feeds address text one character item at a time, predicts each parse result and checks it
// depends on ipv6p_pkg and the ipv6_text_address_parser_unit rtl
`timescale 1ns / 1ps

module tb;
  import ipv6p_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_PCT      = 17;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_t  in_i = '0;
  logic empty;
  logic pop = 1'b0;
  out_t out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;

  ipv6_text_address_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pending character items and the parse results they are due to produce
  in_t        char_queue [$];
  out_t       due_results [$];
  logic [7:0] scratch [$];

  int chars_queued;
  int chars_taken;
  int results_seen;
  int mismatches;

  // predicted parser state
  logic        mode_q;
  logic [15:0] head_grp [8];
  logic [15:0] tail_grp [8];
  logic [15:0] grp_acc;
  int unsigned dig_cnt;
  int unsigned head_n;
  int unsigned tail_n;
  int unsigned pre_val;
  int unsigned pre_dig;
  phase_e      parse_ph;
  logic        bad;

  task automatic clear_text_state();
    for (int i = 0; i < 8; i++) begin
      head_grp[i] = '0;
      tail_grp[i] = '0;
    end
    grp_acc  = '0;
    dig_cnt  = 0;
    head_n   = 0;
    tail_n   = 0;
    pre_val  = 0;
    pre_dig  = 0;
    parse_ph = PH_START;
    bad      = 1'b0;
  endtask

  task automatic commit_head_grp();
    if (head_n < 8) begin
      head_grp[head_n] = grp_acc;
      head_n++;
    end
  endtask

  task automatic commit_tail_grp();
    if (tail_n < 8) begin
      tail_grp[tail_n] = grp_acc;
      tail_n++;
    end
  endtask

  task automatic parse_char(input in_t it);
    logic [7:0]   c;
    logic         is_hex;
    logic [3:0]   hv;
    logic         slash_ok;
    logic         good;
    out_t         res;
    logic [15:0]  g [8];
    logic [127:0] addr;
    logic [127:0] mask;
    c = it.character;
    is_hex = 1'b1;
    hv = '0;
    if (c >= CHAR_0 && c <= CHAR_9) hv = 4'(c - CHAR_0);
    else if (c >= CHAR_LA && c <= CHAR_LF) hv = 4'(c - CHAR_LA + 8'd10);
    else if (c >= CHAR_UA && c <= CHAR_UF) hv = 4'(c - CHAR_UA + 8'd10);
    else is_hex = 1'b0;
    slash_ok = mode_q && c == CHAR_SLASH;
    if (!bad) begin
      case (parse_ph)
        PH_START: begin
          if (c == CHAR_COLON) parse_ph = PH_START_COLON;
          else if (is_hex) begin
            grp_acc = {12'h0, hv};
            dig_cnt = 1;
            parse_ph = PH_HEAD_GROUP;
          end else bad = 1'b1;
        end
        PH_START_COLON: begin
          if (c == CHAR_COLON) parse_ph = PH_ABBREV;
          else bad = 1'b1;
        end
        PH_HEAD_GROUP: begin
          if (is_hex && dig_cnt < MAX_DIGITS) begin
            grp_acc = {grp_acc[11:0], hv};
            dig_cnt++;
          end else begin
            commit_head_grp();
            if (head_n >= NUM_GROUPS) begin
              if (slash_ok) parse_ph = PH_PREFIX;
              else bad = 1'b1;
            end else if (c == CHAR_COLON) parse_ph = PH_HEAD_COLON;
            else bad = 1'b1;
          end
        end
        PH_HEAD_COLON: begin
          if (c == CHAR_COLON) parse_ph = PH_ABBREV;
          else if (is_hex) begin
            grp_acc = {12'h0, hv};
            dig_cnt = 1;
            parse_ph = PH_HEAD_GROUP;
          end else bad = 1'b1;
        end
        PH_ABBREV: begin
          if (is_hex) begin
            if (head_n + 1 + tail_n < NUM_GROUPS) begin
              grp_acc = {12'h0, hv};
              dig_cnt = 1;
              parse_ph = PH_TAIL_GROUP;
            end else bad = 1'b1;
          end else if (slash_ok) parse_ph = PH_PREFIX;
          else bad = 1'b1;
        end
        PH_TAIL_GROUP: begin
          if (is_hex && dig_cnt < MAX_DIGITS) begin
            grp_acc = {grp_acc[11:0], hv};
            dig_cnt++;
          end else begin
            commit_tail_grp();
            if (slash_ok) parse_ph = PH_PREFIX;
            else if (c == CHAR_COLON && head_n + 1 + tail_n < NUM_GROUPS)
              parse_ph = PH_TAIL_COLON;
            else bad = 1'b1;
          end
        end
        PH_TAIL_COLON: begin
          if (is_hex) begin
            grp_acc = {12'h0, hv};
            dig_cnt = 1;
            parse_ph = PH_TAIL_GROUP;
          end else bad = 1'b1;
        end
        PH_PREFIX: begin
          if (c >= CHAR_0 && c <= CHAR_9 && pre_dig < MAX_PDIGITS) begin
            pre_val = pre_val * DEC_BASE + (c - CHAR_0);
            pre_dig++;
          end else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
    end
    if (it.last) begin
      good = 1'b0;
      if (!bad) begin
        case (parse_ph)
          PH_HEAD_GROUP: begin
            commit_head_grp();
            good = head_n == NUM_GROUPS && !mode_q;
          end
          PH_TAIL_GROUP: begin
            commit_tail_grp();
            good = !mode_q;
          end
          PH_ABBREV: good = !mode_q;
          PH_PREFIX: good = mode_q && pre_dig >= 1 && pre_val <= PREFIX_MAX;
          default: good = 1'b0;
        endcase
      end
      res = '0;
      if (good) begin
        for (int i = 0; i < 8; i++) g[i] = '0;
        for (int i = 0; i < head_n; i++) g[i] = head_grp[i];
        for (int i = 0; i < tail_n; i++) g[(8 - tail_n + i) % 8] = tail_grp[i];
        addr = '0;
        for (int i = 0; i < 8; i++) addr = {addr[111:0], g[i]};
        res.ok = 1'b1;
        res.address_high = addr[127:64];
        res.address_low = addr[63:0];
        if (mode_q) begin
          mask = (pre_val == 0) ? 128'h0 : ({128{1'b1}} << (128 - pre_val));
          res.prefix_len = 8'(pre_val);
          res.mask_high = mask[127:64];
          res.mask_low = mask[63:0];
        end
      end
      due_results = {due_results, res};
      clear_text_state();
    end
  endtask

  // sender side
  always @(posedge clk_i) begin
    logic slot_free;
    if (rst_ni) begin
      slot_free = !push || !full;
      if (push && !full) begin
        parse_char(in_i);
        chars_taken++;
      end
      if (slot_free) begin
        if (char_queue.size() != 0 &&
            ((chars_taken >= 200 && chars_taken < 320) || $urandom_range(99) >= IDLE_PCT)) begin
          in_i <= char_queue.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic flag_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch in result %0d, %s: expected %h, got %h", results_seen, name, want, got);
      mismatches++;
    end
  endtask

  // receiver side
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: %h", out_o);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          flag_field("ok", 64'(want.ok), 64'(out_o.ok));
          flag_field("address_high", want.address_high, out_o.address_high);
          flag_field("address_low", want.address_low, out_o.address_low);
          flag_field("prefix_len", 64'(want.prefix_len), 64'(out_o.prefix_len));
          flag_field("mask_high", want.mask_high, out_o.mask_high);
          flag_field("mask_low", want.mask_low, out_o.mask_low);
        end
        results_seen++;
      end
      pop <= (results_seen >= 20 && results_seen < 40) || $urandom_range(99) >= IDLE_PCT;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (char_queue.size() != 0 || push || due_results.size() != 0);
  endtask

  task automatic set_mode(input logic m);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_data_i <= m;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    mode_q = m;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic append_char(input logic [7:0] b);
    scratch = {scratch, b};
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endtask

  // moves up to cnt characters into the send queue, flagging the text end if fin and scratch runs empty
  task automatic flush_part(input int cnt, input logic fin);
    in_t it;
    if (scratch.size() == 0) append_char(8'($urandom_range(255)));
    for (int i = 0; i < cnt && scratch.size() != 0; i++) begin
      it.character = scratch.pop_front();
      it.last = fin && scratch.size() == 0;
      char_queue = {char_queue, it};
      chars_queued++;
    end
  endtask

  task automatic queue_text(input string s, input logic fin);
    push_str(s);
    flush_part(scratch.size(), fin);
  endtask

  task automatic push_group(input int digits);
    int v;
    for (int i = 0; i < digits; i++) begin
      v = $urandom_range(15);
      if (v < 10) append_char(CHAR_0 + 8'(v));
      else if ($urandom_range(1)) append_char(CHAR_UA + 8'(v - 10));
      else append_char(CHAR_LA + 8'(v - 10));
    end
  endtask

  task automatic build_text(input logic pm);
    int    kind;
    int    total;
    int    nh;
    int    nt;
    int    pos;
    int    v;
    string dec;
    string noise_set;
    kind = $urandom_range(99);
    noise_set = ":/09aF.";
    if (kind < 10) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(1)) append_char(8'($urandom_range(255)));
        else append_char(noise_set[$urandom_range(noise_set.len() - 1)]);
      end
    end else begin
      if ($urandom_range(99) < 65) begin
        total = ($urandom_range(99) < 10) ? 7 : $urandom_range(6);
        nh = $urandom_range(total);
        nt = total - nh;
        for (int i = 0; i < nh; i++) begin
          if (i != 0) append_char(CHAR_COLON);
          push_group(($urandom_range(99) < 4) ? 5 : $urandom_range(1, 4));
        end
        push_str("::");
        for (int i = 0; i < nt; i++) begin
          if (i != 0) append_char(CHAR_COLON);
          push_group(($urandom_range(99) < 4) ? 5 : $urandom_range(1, 4));
        end
      end else begin
        kind = $urandom_range(19);
        total = (kind == 0) ? 7 : (kind == 1) ? 9 : 8;
        for (int i = 0; i < total; i++) begin
          if (i != 0) append_char(CHAR_COLON);
          push_group(($urandom_range(99) < 4) ? 5 : $urandom_range(1, 4));
        end
      end
      if (pm ? $urandom_range(99) < 92 : $urandom_range(99) < 8) begin
        append_char(CHAR_SLASH);
        v = ($urandom_range(99) < 10) ? $urandom_range(129, 999) : $urandom_range(128);
        dec = $sformatf("%0d", v);
        if (dec.len() < 3 && $urandom_range(3) == 0) dec = {"0", dec};
        if ($urandom_range(19) == 0) dec = {"0", dec};
        if ($urandom_range(19) == 0) dec = "";
        push_str(dec);
      end
      if ($urandom_range(99) < 20 && scratch.size() != 0) begin
        pos = $urandom_range(scratch.size() - 1);
        case ($urandom_range(2))
          0: scratch[pos] = 8'($urandom_range(255));
          1: scratch.delete(pos);
          default: scratch.insert(pos, CHAR_COLON);
        endcase
      end
    end
    if (scratch.size() == 0) append_char(8'($urandom_range(255)));
  endtask

  initial begin
    int   phase_no;
    int   cut;
    logic m;
    clear_text_state();
    mode_q = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_mode(1'b0);
    queue_text("::", 1'b1);
    queue_text("1:2:3:4:5:6:7:8", 1'b1);
    queue_text("ffff:FFFF:aBcD:0::9:Ef", 1'b1);
    queue_text("12345::1", 1'b1);
    queue_text("1:2:3:4:5:6:7:8:9", 1'b1);
    queue_text("1:2:3::4:5:6:7", 1'b1);
    queue_text(":1::", 1'b1);
    queue_text("1:::2", 1'b1);
    queue_text("1:2:", 1'b1);
    queue_text("1::2::3", 1'b1);
    queue_text("1: 2", 1'b1);
    push_str("::");
    append_char(8'h00);
    flush_part(scratch.size(), 1'b1);
    append_char(8'hFF);
    flush_part(scratch.size(), 1'b1);
    queue_text("1::/64", 1'b1);
    queue_text(":", 1'b1);
    queue_text("fe80::", 1'b0);
    set_mode(1'b1);
    queue_text("/10", 1'b1);
    queue_text("::/0", 1'b1);
    queue_text("1::/128", 1'b1);
    queue_text("::1/129", 1'b1);
    queue_text("1::/", 1'b1);
    queue_text("::/0001", 1'b1);
    queue_text("::/1a", 1'b1);
    queue_text("::/064", 1'b1);
    queue_text("1:2:3:4:5:6:7:8/64", 1'b1);
    queue_text("a::b/65", 1'b1);
    queue_text("1:2:3:4:5:6:7:8", 1'b1);
    queue_text("::1/", 1'b0);
    set_mode(1'b0);
    queue_text("8", 1'b1);

    phase_no = 0;
    while (chars_queued < 440) begin
      m = phase_no[0] ^ ($urandom_range(3) == 0);
      set_mode(m);
      repeat ($urandom_range(3, 9)) begin
        build_text(m);
        flush_part(scratch.size(), 1'b1);
      end
      if ($urandom_range(2) == 0) begin
        build_text(m);
        if (scratch.size() >= 2) begin
          cut = $urandom_range(1, scratch.size() - 1);
          flush_part(cut, 1'b0);
          set_mode(!m);
        end
        flush_part(scratch.size(), 1'b1);
      end
      phase_no++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES * 2) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
